// ===== src/ibfp_pkg.sv =====
// Package for the instruction bit-field packer: widths, codes and shared types.
// No dependencies; used by every module of the block.
package ibfp_pkg;

   localparam int FIELD_W          = 64;   // widest field in bits
   localparam int WIDTH_W          = 7;    // field width port
   localparam int BYTE_W           = 8;
   localparam int NIBBLE_BYTES     = 8;    // bytes in one field value
   localparam int CFG_BYTES_W      = 5;    // fixed_width_bytes register
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 5;
   localparam int STATUS_W         = 2;
   localparam int QUEUE_DEPTH      = 2;
   localparam int DEFAULT_MAX_INSTR_BYTES = 16;

   localparam logic [CFG_BYTES_W-1:0] FIXED_BYTES_RESET = CFG_BYTES_W'(4);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LITTLE_ENDIAN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_CHECK   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_BYTES   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ALIGN    = 2'd1,
      STATUS_WIDTH    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      ST_PACK = 1'b0,
      ST_EMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      logic                   little_endian;
      logic                   fixed_check;
      logic [CFG_BYTES_W-1:0] fixed_bytes;
   } cfg_type;

   // field after width saturation, byte swap and masking
   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [WIDTH_W-1:0] width;
      logic               last;
   } field_item_type;

   typedef struct packed {
      logic           valid;
      field_item_type item;
   } q_link_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
      status_type        status;
   } rsp_word_type;

endpackage

// ===== src/ibfp_front.sv =====
// Front end of the packer: classifies incoming fields and queues them.
// Depends on ibfp_pkg.
module ibfp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ibfp_pkg::FIELD_W-1:0]  req_token_value,
   input  logic [ibfp_pkg::WIDTH_W-1:0]  req_field_width,
   input  logic                          req_swap_operand_bytes,
   input  logic                          req_last_token,
   output ibfp_pkg::q_link_type          q_link,
   input  logic                          q_pop
);

   localparam int QPTR_W = (ibfp_pkg::QUEUE_DEPTH > 1) ? $clog2(ibfp_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(ibfp_pkg::QUEUE_DEPTH + 1);
   localparam int NB_W   = $clog2(ibfp_pkg::NIBBLE_BYTES + 1);

   ibfp_pkg::field_item_type queue_ff [ibfp_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic [ibfp_pkg::WIDTH_W-1:0] width_sat;
   logic [NB_W-1:0]              nbytes;
   logic [ibfp_pkg::FIELD_W-1:0] swapped;
   logic [ibfp_pkg::FIELD_W-1:0] masked;
   ibfp_pkg::field_item_type     item_new;
   logic                         do_push;
   logic                         do_pop;

   // classify: saturate width, optional low-byte reversal, mask
   always_comb begin
      logic [NB_W-1:0] src;
      width_sat = (req_field_width > ibfp_pkg::WIDTH_W'(ibfp_pkg::FIELD_W))
                ? ibfp_pkg::WIDTH_W'(ibfp_pkg::FIELD_W) : req_field_width;
      nbytes    = NB_W'((width_sat + ibfp_pkg::WIDTH_W'(7)) >> 3);
      swapped   = req_token_value;
      for (int k = 0; k < ibfp_pkg::NIBBLE_BYTES; k++) begin
         src = nbytes - NB_W'(1) - NB_W'(k);
         if (req_swap_operand_bytes && (NB_W'(k) < nbytes)) begin
            swapped[k*8 +: 8] = req_token_value[src[2:0]*8 +: 8];
         end
      end
      if (width_sat < ibfp_pkg::WIDTH_W'(ibfp_pkg::FIELD_W)) begin
         masked = swapped & ~({ibfp_pkg::FIELD_W{1'b1}} << width_sat);
      end else begin
         masked = swapped;
      end
      item_new.value = masked;
      item_new.width = width_sat;
      item_new.last  = req_last_token;
   end

   assign req_full = (count_ff == QCNT_W'(ibfp_pkg::QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && (count_ff != '0);

   assign q_link.valid = (count_ff != '0);
   assign q_link.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(ibfp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(ibfp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ===== src/ibfp_back.sv =====
// Back end of the packer: inserts fields into the instruction buffer,
// checks the instruction and emits its bytes. Depends on ibfp_pkg.
module ibfp_back #(
   parameter int MAX_INSTR_BYTES = ibfp_pkg::DEFAULT_MAX_INSTR_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ibfp_pkg::cfg_type     cfg,
   input  ibfp_pkg::q_link_type  q_link,
   output logic                  q_pop,
   output ibfp_pkg::rsp_word_type rsp_word,
   input  logic                  rsp_pop
);

   localparam int TOTAL_BITS = MAX_INSTR_BYTES * ibfp_pkg::BYTE_W;
   localparam int EXT_BITS   = TOTAL_BITS + ibfp_pkg::FIELD_W;
   localparam int CNT_W      = $clog2(MAX_INSTR_BYTES + 1);
   localparam int IDX_W      = (MAX_INSTR_BYTES > 1) ? $clog2(MAX_INSTR_BYTES) : 1;
   localparam int POS_W      = $clog2(TOTAL_BITS + ibfp_pkg::FIELD_W + 8);
   localparam int CMP_W      = (CNT_W > ibfp_pkg::CFG_BYTES_W) ? CNT_W : ibfp_pkg::CFG_BYTES_W;

   ibfp_pkg::back_state_type state_ff, state_in;
   logic [TOTAL_BITS-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]      byte_count_ff, byte_count_in;
   logic [2:0]            bit_offset_ff, bit_offset_in;
   logic                  overflow_ff, overflow_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   ibfp_pkg::rsp_word_type out_ff, out_in;

   logic [POS_W-1:0]      pos;
   logic [POS_W-1:0]      pos_end;
   logic [POS_W-4:0]      end_bytes;
   logic [ibfp_pkg::FIELD_W-1:0] aligned;
   logic [EXT_BITS-1:0]   placed;
   logic [TOTAL_BITS-1:0] keep_mask;
   logic [TOTAL_BITS-1:0] packed_buf;
   ibfp_pkg::status_type  status;
   logic                  can_emit;
   logic [IDX_W-1:0]      last_idx;
   logic [IDX_W-1:0]      src;
   logic [TOTAL_BITS-1:0] rd_word;

   // insertion of one field at the current bit position
   assign pos     = POS_W'({byte_count_ff, bit_offset_ff});
   assign pos_end = pos + POS_W'(q_link.item.width);
   assign end_bytes = pos_end[POS_W-1:3];
   assign aligned = q_link.item.value
                  << (ibfp_pkg::WIDTH_W'(ibfp_pkg::FIELD_W) - q_link.item.width);
   assign placed  = {aligned, {TOTAL_BITS{1'b0}}} >> pos;
   assign keep_mask = ~({TOTAL_BITS{1'b1}} >> pos);
   assign packed_buf = (buf_ff & keep_mask) | placed[EXT_BITS-1 -: TOTAL_BITS];

   // end-of-instruction checks, in priority order
   always_comb begin
      if (bit_offset_ff != 3'd0) begin
         status = ibfp_pkg::STATUS_ALIGN;
      end else if (cfg.fixed_check &&
                   (CMP_W'(byte_count_ff) != CMP_W'(cfg.fixed_bytes))) begin
         status = ibfp_pkg::STATUS_WIDTH;
      end else if (overflow_ff) begin
         status = ibfp_pkg::STATUS_OVERFLOW;
      end else begin
         status = ibfp_pkg::STATUS_OK;
      end
   end

   assign can_emit = !out_ff.valid || rsp_pop;
   assign last_idx = IDX_W'(byte_count_ff - CNT_W'(1));
   assign src      = cfg.little_endian ? (last_idx - idx_ff) : idx_ff;
   assign rd_word  = buf_ff << {src, 3'b000};

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      byte_count_in = byte_count_ff;
      bit_offset_in = bit_offset_ff;
      overflow_in   = overflow_ff;
      idx_in        = idx_ff;
      out_in        = out_ff;
      q_pop         = 1'b0;
      if (rsp_pop) begin
         out_in.valid = 1'b0;
      end
      case (state_ff)
         ibfp_pkg::ST_PACK: begin
            if (q_link.valid) begin
               q_pop         = 1'b1;
               buf_in        = packed_buf;
               bit_offset_in = pos_end[2:0];
               byte_count_in = (end_bytes > (POS_W-3)'(MAX_INSTR_BYTES))
                             ? CNT_W'(MAX_INSTR_BYTES) : CNT_W'(end_bytes);
               if (pos_end > POS_W'(TOTAL_BITS)) begin
                  overflow_in = 1'b1;
               end
               if (q_link.item.last) begin
                  idx_in   = '0;
                  state_in = ibfp_pkg::ST_EMIT;
               end
            end
         end
         ibfp_pkg::ST_EMIT: begin
            if (status != ibfp_pkg::STATUS_OK) begin
               if (can_emit) begin
                  out_in.valid     = 1'b1;
                  out_in.out_byte  = '0;
                  out_in.last_byte = 1'b1;
                  out_in.status    = status;
                  byte_count_in    = '0;
                  bit_offset_in    = '0;
                  overflow_in      = 1'b0;
                  state_in         = ibfp_pkg::ST_PACK;
               end
            end else if (byte_count_ff == '0) begin
               // empty instruction: nothing to send
               overflow_in = 1'b0;
               state_in    = ibfp_pkg::ST_PACK;
            end else if (can_emit) begin
               out_in.valid     = 1'b1;
               out_in.out_byte  = rd_word[TOTAL_BITS-1 -: ibfp_pkg::BYTE_W];
               out_in.last_byte = (idx_ff == last_idx);
               out_in.status    = ibfp_pkg::STATUS_OK;
               if (idx_ff == last_idx) begin
                  byte_count_in = '0;
                  bit_offset_in = '0;
                  overflow_in   = 1'b0;
                  state_in      = ibfp_pkg::ST_PACK;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ibfp_pkg::ST_PACK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibfp_pkg::ST_PACK;
         byte_count_ff <= '0;
         bit_offset_ff <= '0;
         overflow_ff   <= 1'b0;
         idx_ff        <= '0;
         out_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         bit_offset_ff <= bit_offset_in;
         overflow_ff   <= overflow_in;
         idx_ff        <= idx_in;
         out_ff        <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_word = out_ff;

endmodule

// ===== src/instruction_bit_field_packer.sv =====
// Top level of the instruction bit-field packer: config registers, front
// and back ends, assertions. Depends on ibfp_pkg, ibfp_front, ibfp_back.
//  - Input words (one bit field each) go in like a queue: drive the req_
//    fields and raise req_push; the word is taken on an edge with req_full
//    low. Fields pack MSB first; req_last_token closes the instruction.
//  - Result words come out like a queue: while rsp_empty is low the oldest
//    word sits on the rsp_ ports and is taken on an edge with rsp_pop high.
//    An ok instruction gives one word per byte, last one marked; an error
//    gives a single zero word with rsp_last_byte set and the error status.
//  - Timing: a two-entry queue parts front and back. The back end packs one
//    field per cycle while the queue holds one, then checks and emits one
//    byte per cycle while the receiver keeps up, the check sharing the
//    cycle of the first byte. A closing word goes through the queue, the
//    back end's pack and emit states, then into the output register.
//  - A stalled receiver (rsp_pop low) holds the output register and the
//    emitting back end; the queue then fills and req_full rises.
//  - Synchronous reset clears the queue, packing state and output register
//    and sets config defaults (little endian off, check off, 4 bytes). The
//    buffer is not cleared; every byte is written before it is read.
//  - Write csr_ registers only while the block is idle; it is not enforced.
module instruction_bit_field_packer #(
   parameter int MAX_INSTR_BYTES = ibfp_pkg::DEFAULT_MAX_INSTR_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   // input queue
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [ibfp_pkg::FIELD_W-1:0]     req_token_value,
   input  logic [ibfp_pkg::WIDTH_W-1:0]     req_field_width,
   input  logic                             req_swap_operand_bytes,
   input  logic                             req_last_token,
   // result queue
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ibfp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_last_byte,
   output logic [ibfp_pkg::STATUS_W-1:0]    rsp_status,
   // configuration
   input  logic                             csr_we,
   input  logic [ibfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ibfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ibfp_pkg::cfg_type      cfg_ff, cfg_in;
   ibfp_pkg::q_link_type   q_link;
   logic                   q_pop;
   ibfp_pkg::rsp_word_type rsp_word;

   // config register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ibfp_pkg::CSR_LITTLE_ENDIAN: cfg_in.little_endian = csr_wdata[0];
            ibfp_pkg::CSR_FIXED_CHECK:   cfg_in.fixed_check   = csr_wdata[0];
            ibfp_pkg::CSR_FIXED_BYTES:
               cfg_in.fixed_bytes = csr_wdata[ibfp_pkg::CFG_BYTES_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.little_endian <= 1'b0;
         cfg_ff.fixed_check   <= 1'b0;
         cfg_ff.fixed_bytes   <= ibfp_pkg::FIXED_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ibfp_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_token_value        (req_token_value),
      .req_field_width        (req_field_width),
      .req_swap_operand_bytes (req_swap_operand_bytes),
      .req_last_token         (req_last_token),
      .q_link                 (q_link),
      .q_pop                  (q_pop)
   );

   ibfp_back #(
      .MAX_INSTR_BYTES (MAX_INSTR_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_link   (q_link),
      .q_pop    (q_pop),
      .rsp_word (rsp_word),
      .rsp_pop  (rsp_pop)
   );

   assign rsp_empty     = !rsp_word.valid;
   assign rsp_out_byte  = rsp_word.out_byte;
   assign rsp_last_byte = rsp_word.last_byte;
   assign rsp_status    = rsp_word.status;

   // the back end only takes a field that the queue holds
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_link.valid)
      else $error("back end popped an empty field queue");

   // an error word is always a lone zero word marked last
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ibfp_pkg::STATUS_OK)
         |-> (rsp_last_byte && rsp_out_byte == '0))
      else $error("error result is not a zero last word");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");

   // a full queue stays full until the back end takes a field
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_full && !q_pop) |=> req_full)
      else $error("field queue lost an entry");

endmodule

// ===== tb/sv/ibfp_checker.sv =====
// Checker for the instruction bit-field packer: watches the req_, rsp_ and csr_ ports,
// predicts the bytes of every instruction and compares each result word with them.
// Depends on ibfp_pkg.
module ibfp_checker #(
   parameter int MAX_BYTES = ibfp_pkg::DEFAULT_MAX_INSTR_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  logic [ibfp_pkg::FIELD_W-1:0]     req_token_value,
   input  logic [ibfp_pkg::WIDTH_W-1:0]     req_field_width,
   input  logic                             req_swap_operand_bytes,
   input  logic                             req_last_token,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic [ibfp_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                             rsp_last_byte,
   input  logic [ibfp_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                             csr_we,
   input  logic [ibfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ibfp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               words_pending,
   output int                               words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ibfp_pkg::BYTE_W-1:0] data;
      logic                        last;
      ibfp_pkg::status_type        status;
   } instr_byte_type;

   instr_byte_type              expected_bytes[$];
   logic [ibfp_pkg::BYTE_W-1:0] instr_buf[MAX_BYTES];
   int unsigned                 byte_count;
   int unsigned                 bit_offset;
   logic                        overflow_seen;
   ibfp_pkg::cfg_type           cfg;

   // Append one field MSB first; on the closing field queue the words it yields.
   task automatic pack_field(input logic [ibfp_pkg::FIELD_W-1:0] value,
                             input logic [ibfp_pkg::WIDTH_W-1:0] width_in,
                             input logic swap, input logic last);
      int unsigned width;
      int unsigned nbytes;
      int unsigned src;
      logic [ibfp_pkg::FIELD_W-1:0] v;
      logic [ibfp_pkg::FIELD_W-1:0] swapped;
      ibfp_pkg::status_type st;
      width = (width_in > 64) ? 64 : width_in;
      v = value;
      if (swap) begin
         nbytes = (width + 7) / 8;
         swapped = v;
         for (int k = 0; k < nbytes; k++)
            swapped[k*8 +: 8] = v[(nbytes-1-k)*8 +: 8];
         v = swapped;
      end
      if (width < 64)
         v &= (64'd1 << width) - 64'd1;
      for (int i = width; i > 0; i--) begin
         if (byte_count >= MAX_BYTES)
            overflow_seen = 1'b1;
         else if (bit_offset == 0)
            instr_buf[byte_count] = {v[i-1], 7'b0};
         else
            instr_buf[byte_count][7-bit_offset] = v[i-1];
         bit_offset++;
         if (bit_offset == 8) begin
            bit_offset = 0;
            if (byte_count < MAX_BYTES)
               byte_count++;
         end
      end
      if (!last)
         return;
      // error priority: alignment, then length, then overflow
      if (bit_offset != 0)
         st = ibfp_pkg::STATUS_ALIGN;
      else if (cfg.fixed_check && byte_count != cfg.fixed_bytes)
         st = ibfp_pkg::STATUS_WIDTH;
      else if (overflow_seen)
         st = ibfp_pkg::STATUS_OVERFLOW;
      else
         st = ibfp_pkg::STATUS_OK;
      if (st != ibfp_pkg::STATUS_OK) begin
         expected_bytes.push_back('{8'h00, 1'b1, st});
      end else begin
         for (int i = 0; i < byte_count; i++) begin
            src = cfg.little_endian ? byte_count - 1 - i : i;
            expected_bytes.push_back('{instr_buf[src], (i + 1 == byte_count),
                                       ibfp_pkg::STATUS_OK});
         end
      end
      byte_count = 0;
      bit_offset = 0;
      overflow_seen = 1'b0;
   endtask

   always @(posedge clock) begin
      instr_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         byte_count = 0;
         bit_offset = 0;
         overflow_seen = 1'b0;
         cfg = '{1'b0, 1'b0, ibfp_pkg::FIXED_BYTES_RESET};
         mismatch_count = 0;
         words_checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ibfp_pkg::CSR_LITTLE_ENDIAN: cfg.little_endian = csr_wdata[0];
               ibfp_pkg::CSR_FIXED_CHECK:   cfg.fixed_check = csr_wdata[0];
               ibfp_pkg::CSR_FIXED_BYTES:   cfg.fixed_bytes = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full)
            pack_field(req_token_value, req_field_width, req_swap_operand_bytes,
                       req_last_token);
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected word: byte %02h last %0b status %0d",
                           $time, rsp_out_byte, rsp_last_byte, rsp_status);
            end else begin
               want = expected_bytes.pop_front();
               words_checked++;
               if (rsp_out_byte !== want.data || rsp_last_byte !== want.last ||
                   rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: word %0d: expected byte %02h last %0b status %s,",
                               " got byte %02h last %0b status %0d"},
                              $time, words_checked, want.data, want.last,
                              want.status.name(), rsp_out_byte, rsp_last_byte,
                              rsp_status);
               end
            end
         end
      end
      words_pending = expected_bytes.size();
   end

endmodule

// ===== tb/sv/instruction_bit_field_packer_test.sv =====
// Top of the instruction bit-field packer testbench: clock, reset, stimulus and verdict.
// Depends on ibfp_pkg, instruction_bit_field_packer and ibfp_checker.
module instruction_bit_field_packer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 300_000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES = 24;       // covers fields still in the pipe with no word due
   localparam int PHASE_FIELDS  = 12;       // random fields per csr/idle phase, at least
   localparam int NUM_PHASES    = 6;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic [ibfp_pkg::FIELD_W-1:0]     req_token_value = '0;
   logic [ibfp_pkg::WIDTH_W-1:0]     req_field_width = '0;
   logic                             req_swap_operand_bytes = 1'b0;
   logic                             req_last_token = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [ibfp_pkg::BYTE_W-1:0]      rsp_out_byte;
   logic                             rsp_last_byte;
   logic [ibfp_pkg::STATUS_W-1:0]    rsp_status;
   logic                             csr_we = 1'b0;
   logic [ibfp_pkg::CSR_INDEX_W-1:0] csr_index = ibfp_pkg::CSR_LITTLE_ENDIAN;
   logic [ibfp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int words_pending;
   int words_checked;

   int          cycle_count = 0;
   int          fields_sent = 0;
   int unsigned idle_pct = 0;    // chance in 100 that the sender skips a cycle
   int unsigned stall_pct = 0;   // chance in 100 that the receiver holds off a cycle
   logic        le_now = 1'b0;
   logic        chk_now = 1'b0;
   logic [4:0]  fb_now = ibfp_pkg::FIXED_BYTES_RESET;

   instruction_bit_field_packer dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_token_value        (req_token_value),
      .req_field_width        (req_field_width),
      .req_swap_operand_bytes (req_swap_operand_bytes),
      .req_last_token         (req_last_token),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last_byte          (rsp_last_byte),
      .rsp_status             (rsp_status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // Independent observer: predicts every word and compares, reports a failure count.
   ibfp_checker byte_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_token_value        (req_token_value),
      .req_field_width        (req_field_width),
      .req_swap_operand_bytes (req_swap_operand_bytes),
      .req_last_token         (req_last_token),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_last_byte          (rsp_last_byte),
      .rsp_status             (rsp_status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .mismatch_count         (mismatch_count),
      .words_pending          (words_pending),
      .words_checked          (words_checked)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, words_pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: pop decided fresh every cycle, held off stall_pct of the time.
   always @(negedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [ibfp_pkg::FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one field word. Called at a falling edge; returns at the falling edge after
   // the word was taken, with push still high so back-to-back words leave no gap.
   task automatic send_field(input logic [ibfp_pkg::FIELD_W-1:0] value,
                             input int unsigned width,
                             input logic swap, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_token_value <= value;
      req_field_width <= ibfp_pkg::WIDTH_W'(width);
      req_swap_operand_bytes <= swap;
      req_last_token <= last;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      fields_sent++;
   endtask

   // Stop offering words and let the block run dry; csr writes are only safe after this.
   task automatic drain();
      req_push <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all three registers, one per cycle, we held high across them.
   task automatic set_config(input logic le, input logic chk, input logic [4:0] fb);
      csr_we <= 1'b1;
      csr_index <= ibfp_pkg::CSR_LITTLE_ENDIAN;
      csr_wdata <= ibfp_pkg::CSR_DATA_W'(le);
      @(negedge clock);
      csr_index <= ibfp_pkg::CSR_FIXED_CHECK;
      csr_wdata <= ibfp_pkg::CSR_DATA_W'(chk);
      @(negedge clock);
      csr_index <= ibfp_pkg::CSR_FIXED_BYTES;
      csr_wdata <= fb;
      @(negedge clock);
      csr_we <= 1'b0;
      le_now = le;
      chk_now = chk;
      fb_now = fb;
   endtask

   // Byte-aligned instruction of nbytes split into random-width fields, with the odd
   // zero-width filler, saturating width code or zero-width closing field mixed in.
   task automatic send_aligned(input int unsigned nbytes);
      int unsigned bits_left;
      int unsigned w;
      bit          zero_tail;
      bits_left = nbytes * 8;
      zero_tail = ($urandom_range(7) == 0);
      while (bits_left > 0) begin
         if ($urandom_range(9) == 0)
            send_field(rand64(), 0, 1'($urandom_range(1)), 1'b0);
         w = $urandom_range(bits_left < 64 ? bits_left : 64, 1);
         bits_left -= w;
         if (w == 64 && $urandom_range(1))
            w = $urandom_range(127, 65);
         send_field(rand64(), w, 1'($urandom_range(1)), bits_left == 0 && !zero_tail);
      end
      if (zero_tail)
         send_field(rand64(), 0, 1'($urandom_range(1)), 1'b1);
   endtask

   // One random instruction: mostly well formed, the rest overflow, empty or noise.
   task automatic send_instruction();
      int unsigned pick;
      int unsigned nbytes;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // with the length check on, usually hit the required length
         if (chk_now && fb_now >= 1 && fb_now <= 16 && $urandom_range(4) != 0)
            nbytes = fb_now;
         else if ($urandom_range(3) == 0)
            nbytes = $urandom_range(16, 1);
         else
            nbytes = $urandom_range(4, 1);
         send_aligned(nbytes);
      end else if (pick < 80) begin
         send_aligned($urandom_range(20, 17));   // runs past the buffer
      end else if (pick < 85) begin
         send_field(rand64(), 0, 1'($urandom_range(1)), 1'b1);
      end else begin
         // free-form fields: mostly misaligned, sometimes oversized
         n = $urandom_range(4, 1);
         for (int k = 1; k <= n; k++)
            send_field(rand64(),
                       $urandom_range(2) ? $urandom_range(40, 0) : $urandom_range(127, 41),
                       1'($urandom_range(1)), k == n);
      end
   endtask

   initial begin
      int phase_start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed: reset config (big endian, no length check) ----
      send_field(64'hFFFF_FFFF_FFFF_FFA5, 8, 1'b0, 1'b1);      // single byte, upper bits masked
      send_field(64'h0123_4567_89AB_CDEF, 64, 1'b1, 1'b1);     // full-width field, byte swapped
      send_field('1, 127, 1'b0, 1'b1);                         // width code saturates to 64
      send_field(rand64(), 0, 1'b1, 1'b0);                     // zero width, swap is a no-op
      send_field(64'h1234_5678_9ABC_DEF0, 12, 1'b1, 1'b0);     // swap of one full and one partial byte
      send_field(64'h0000_0000_0000_0009, 4, 1'b0, 1'b1);
      send_field(64'd0, 0, 1'b0, 1'b1);                        // empty instruction: no word
      send_field(64'd5, 3, 1'b0, 1'b1);                        // not byte aligned
      send_field('1, 64, 1'b0, 1'b0);                          // 17 bytes: buffer overflow
      send_field(64'd0, 64, 1'b0, 1'b0);
      send_field('1, 8, 1'b0, 1'b1);
      send_field(64'd1, 1, 1'b0, 1'b0);                        // single-bit field
      send_field(64'h55, 7, 1'b0, 1'b1);
      drain();

      // ---- directed: little endian, 4-byte length check ----
      set_config(1'b1, 1'b1, 5'd4);
      send_field(64'hDEAD_BEEF, 32, 1'b0, 1'b1);              // ok, bytes reversed
      send_field(64'hABCDEF, 24, 1'b0, 1'b1);                  // wrong length
      send_field(64'hABCDE, 20, 1'b0, 1'b1);                   // misaligned wins over length
      send_field('1, 64, 1'b1, 1'b0);                          // overflow, length reported
      send_field('1, 64, 1'b0, 1'b0);
      send_field('1, 8, 1'b0, 1'b1);
      send_field(64'd0, 0, 1'b0, 1'b1);                        // empty but length required
      drain();

      // ---- directed: required length zero ----
      set_config(1'b0, 1'b1, 5'd0);
      send_field(64'd0, 0, 1'b0, 1'b1);                        // empty passes silently
      send_field(64'h3C, 8, 1'b0, 1'b1);                       // any byte fails the check
      drain();

      // ---- random phases: each with its own csr setting and idle pattern ----
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin set_config(1'b0, 1'b0, 5'd4);  idle_pct = 0;  stall_pct = 0;  end
            1: begin set_config(1'b1, 1'b1, 5'd16); idle_pct = 79; stall_pct = 0;  end
            2: begin set_config(1'b0, 1'b1, 5'd1);  idle_pct = 0;  stall_pct = 79; end
            3: begin set_config(1'b1, 1'b0, 5'd31); idle_pct = 9;  stall_pct = 9;  end
            4: begin set_config(1'b1, 1'b1, 5'd31); idle_pct = 0;  stall_pct = 0;  end
            default: begin set_config(1'b0, 1'b1, 5'd8); idle_pct = 9; stall_pct = 9; end
         endcase
         phase_start = fields_sent;
         while (fields_sent - phase_start < PHASE_FIELDS)
            send_instruction();
         // sender holds off until every word of the phase has come back
         drain();
      end

      $display("Covered %0d field words over directed cases and %0d csr/idle phases;",
               fields_sent, NUM_PHASES);
      $display("%0d result words checked, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
